// ----- src/ets_pkg.sv -----
// ----------------------------------------------------------------------------
// Event timestamp sanitizer package
// Shared constants, register indexes, verdict codes and the flag bundle
// passed from the classifier to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ets_pkg;

   localparam int TS_WIDTH_DEFAULT      = 64;
   localparam int PAYLOAD_WIDTH_DEFAULT = 64;

   // Configuration port: 64-bit data, registers on 8-byte boundaries.
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_NUM_REGS   = 4;
   localparam int CSR_INDEX_LSB  = 3;
   localparam int CSR_ADDR_WIDTH = CSR_INDEX_LSB + $clog2(CSR_NUM_REGS);

   typedef enum logic [$clog2(CSR_NUM_REGS)-1:0] {
      REG_TS_MINIMUM    = 2'd0,
      REG_TS_MAXIMUM    = 2'd1,
      REG_JUMP_THRESHOLD = 2'd2,
      REG_SPLIT_MODE    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_KEPT         = 2'd0,
      VERDICT_OUT_OF_RANGE = 2'd1,
      VERDICT_FORWARD      = 2'd2,
      VERDICT_BACKWARD     = 2'd3
   } verdict_type;

   typedef struct packed {
      verdict_type verdict;
      logic        kept;
      logic        new_segment;
      logic        load_offset;
   } cls_flags_type;

endpackage

`default_nettype wire

// ----- src/ets_req_if.sv -----
// ----------------------------------------------------------------------------
// Event input channel
// Valid/ready channel carrying one raw event record per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ets_req_if #(
   parameter int TS_WIDTH      = ets_pkg::TS_WIDTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = ets_pkg::PAYLOAD_WIDTH_DEFAULT
);
   logic                     valid;
   logic                     ready;
   logic [TS_WIDTH-1:0]      raw_timestamp;
   logic [PAYLOAD_WIDTH-1:0] event_payload;
   logic                     end_of_stream;

   modport source (
      output valid, raw_timestamp, event_payload, end_of_stream,
      input  ready
   );

   modport sink (
      input  valid, raw_timestamp, event_payload, end_of_stream,
      output ready
   );
endinterface

`default_nettype wire

// ----- src/ets_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Classified event output channel
// Valid/ready channel carrying one classified event record per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ets_rsp_if #(
   parameter int TS_WIDTH      = ets_pkg::TS_WIDTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = ets_pkg::PAYLOAD_WIDTH_DEFAULT
);
   logic                     valid;
   logic                     ready;
   logic [TS_WIDTH-1:0]      out_timestamp;
   logic [PAYLOAD_WIDTH-1:0] out_payload;
   ets_pkg::verdict_type     verdict;
   logic                     new_segment;
   logic                     run_last;

   modport source (
      output valid, out_timestamp, out_payload, verdict, new_segment, run_last,
      input  ready
   );

   modport sink (
      input  valid, out_timestamp, out_payload, verdict, new_segment, run_last,
      output ready
   );
endinterface

`default_nettype wire

// ----- src/ets_csr.sv -----
// ----------------------------------------------------------------------------
// Event timestamp sanitizer configuration registers
// APB-style register file for range limits, jump threshold and split mode.
// ----------------------------------------------------------------------------
`default_nettype none

module ets_csr #(
   parameter int TS_WIDTH = ets_pkg::TS_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ets_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [ets_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [ets_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                               pready,
   output logic [TS_WIDTH-1:0]                ts_minimum,
   output logic [TS_WIDTH-1:0]                ts_maximum,
   output logic                               split_mode,
   output logic                               thr_load,
   output logic [TS_WIDTH-1:0]                thr_value
);
   import ets_pkg::*;

   logic [TS_WIDTH-1:0] ts_minimum_ff;
   logic [TS_WIDTH-1:0] ts_maximum_ff;
   logic [TS_WIDTH-1:0] jump_threshold_ff;
   logic                split_mode_ff;
   csr_index_type       index;
   logic                wr_en;

   assign index  = csr_index_type'(paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB]);
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // The top level keeps sums that include the threshold, so it is told
   // when the threshold changes and what the new value is.
   assign thr_load  = wr_en && (index == REG_JUMP_THRESHOLD);
   assign thr_value = TS_WIDTH'(pwdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_minimum_ff     <= '0;
         ts_maximum_ff     <= '1;
         jump_threshold_ff <= '0;
         split_mode_ff     <= 1'b0;
      end else if (wr_en) begin
         unique case (index)
            REG_TS_MINIMUM:     ts_minimum_ff     <= TS_WIDTH'(pwdata);
            REG_TS_MAXIMUM:     ts_maximum_ff     <= TS_WIDTH'(pwdata);
            REG_JUMP_THRESHOLD: jump_threshold_ff <= TS_WIDTH'(pwdata);
            REG_SPLIT_MODE:     split_mode_ff     <= pwdata[0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_TS_MINIMUM:     prdata = CSR_DATA_WIDTH'(ts_minimum_ff);
         REG_TS_MAXIMUM:     prdata = CSR_DATA_WIDTH'(ts_maximum_ff);
         REG_JUMP_THRESHOLD: prdata = CSR_DATA_WIDTH'(jump_threshold_ff);
         REG_SPLIT_MODE:     prdata = CSR_DATA_WIDTH'(split_mode_ff);
         default:            prdata = '0;
      endcase
   end

   assign ts_minimum = ts_minimum_ff;
   assign ts_maximum = ts_maximum_ff;
   assign split_mode = split_mode_ff;

endmodule

`default_nettype wire

// ----- src/ets_classify.sv -----
// ----------------------------------------------------------------------------
// Event timestamp classifier
// Judges one event against the last kept timestamp and its lookahead.
// ----------------------------------------------------------------------------
`default_nettype none

module ets_classify #(
   parameter int TS_WIDTH = ets_pkg::TS_WIDTH_DEFAULT
) (
   input  logic [TS_WIDTH-1:0]   cls_ts,
   input  logic [TS_WIDTH-1:0]   cls_nxt,
   input  logic [TS_WIDTH-1:0]   offset,
   input  logic [TS_WIDTH-1:0]   offset_thr,
   input  logic [TS_WIDTH-1:0]   prev_kept,
   input  logic [TS_WIDTH-1:0]   prev_thr,
   input  logic [TS_WIDTH-1:0]   ts_minimum,
   input  logic [TS_WIDTH-1:0]   ts_maximum,
   input  logic                  split_mode,
   output logic [TS_WIDTH-1:0]   cur,
   output logic [TS_WIDTH-1:0]   cur_thr,
   output ets_pkg::cls_flags_type flags
);
   import ets_pkg::*;

   logic [TS_WIDTH-1:0] nxt;
   logic [TS_WIDTH-1:0] nxt_thr;
   logic                out_of_range;
   logic                fwd_isolated;
   logic                bwd_isolated;
   logic                real_jump;

   // The offset plus threshold is held as a precomputed sum, so each jump
   // comparison below sees a single adder; the range check uses none.
   assign cur     = cls_ts + offset;
   assign cur_thr = cls_ts + offset_thr;
   assign nxt     = cls_nxt + offset;
   assign nxt_thr = cls_nxt + offset_thr;

   assign out_of_range = (cls_ts < ts_minimum) || (ts_maximum < cls_ts);
   assign fwd_isolated = (prev_thr < cur) && (nxt < prev_thr);
   assign bwd_isolated = (cur_thr < prev_kept) && (prev_kept < nxt_thr);
   assign real_jump    = (cur_thr < prev_kept) && (nxt_thr < prev_kept);

   always_comb begin
      flags = '0;
      if (out_of_range) begin
         flags.verdict = VERDICT_OUT_OF_RANGE;
      end else if (fwd_isolated) begin
         flags.verdict = VERDICT_FORWARD;
      end else if (bwd_isolated) begin
         flags.verdict = VERDICT_BACKWARD;
      end else begin
         flags.verdict     = VERDICT_KEPT;
         flags.kept        = 1'b1;
         flags.new_segment = real_jump && split_mode;
         flags.load_offset = real_jump && !split_mode;
      end
   end

endmodule

`default_nettype wire

// ----- src/event_timestamp_sanitizer_unit.sv -----
// ----------------------------------------------------------------------------
// Event timestamp sanitizer
// Classifies detector events by timestamp with one event of lookahead.
// ----------------------------------------------------------------------------
// Each event is held until the next one arrives, then classified and sent
// out with a verdict, its corrected timestamp and its payload; the first
// event of a stream therefore gives no result until the second arrives.
// The block takes one beat per cycle unless the output stalls or a flush
// holds it off. Beats land in an input register; one classification per
// cycle, while the output is not stalled, runs from there to the output
// register. An end-of-stream beat arriving while an event is held gives
// two results in turn; new beats wait in the input register during the
// flush. run_last marks the final result caused by a beat. Configuration
// writes must be made only while no event is held or in flight.
`default_nettype none

module event_timestamp_sanitizer_unit #(
   parameter int TS_WIDTH      = ets_pkg::TS_WIDTH_DEFAULT,
   parameter int PAYLOAD_WIDTH = ets_pkg::PAYLOAD_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   ets_req_if.sink                            req_bus,
   ets_rsp_if.source                          rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ets_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [ets_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [ets_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                               pready
);
   import ets_pkg::*;

   // Configuration
   logic [TS_WIDTH-1:0] ts_minimum;
   logic [TS_WIDTH-1:0] ts_maximum;
   logic                split_mode;
   logic                thr_load;
   logic [TS_WIDTH-1:0] thr_value;

   // Input register
   logic                     stg_valid_ff;
   logic [TS_WIDTH-1:0]      stg_ts_ff;
   logic [PAYLOAD_WIDTH-1:0] stg_pay_ff;
   logic                     stg_eos_ff;

   // Held event; held_flush_ff marks an end-of-stream event that is its own
   // lookahead and is classified on its own in the next free cycle.
   logic                     held_valid_ff;
   logic                     held_flush_ff;
   logic [TS_WIDTH-1:0]      held_ts_ff;
   logic [PAYLOAD_WIDTH-1:0] held_pay_ff;

   // Correction state with the threshold sums kept alongside
   logic [TS_WIDTH-1:0] offset_ff;
   logic [TS_WIDTH-1:0] offset_thr_ff;
   logic [TS_WIDTH-1:0] prev_kept_ff;
   logic [TS_WIDTH-1:0] prev_thr_ff;

   // Output register
   logic                     out_valid_ff;
   logic [TS_WIDTH-1:0]      out_ts_ff;
   logic [PAYLOAD_WIDTH-1:0] out_pay_ff;
   verdict_type              out_verdict_ff;
   logic                     out_seg_ff;
   logic                     out_last_ff;

   logic                     slot_free;
   logic                     flush_mode;
   logic                     fire;
   logic                     stg_take;
   logic                     emit;
   logic                     last;
   logic                     held_valid_in;
   logic                     held_flush_in;
   logic [TS_WIDTH-1:0]      cls_ts;
   logic [PAYLOAD_WIDTH-1:0] cls_pay;
   logic [TS_WIDTH-1:0]      cls_nxt;
   logic [TS_WIDTH-1:0]      cls_cur;
   logic [TS_WIDTH-1:0]      cls_cur_thr;
   cls_flags_type            cls_flags;

   ets_csr #(
      .TS_WIDTH (TS_WIDTH)
   ) u_csr (
      .clock          (clock),
      .reset          (reset),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready),
      .ts_minimum     (ts_minimum),
      .ts_maximum     (ts_maximum),
      .split_mode     (split_mode),
      .thr_load       (thr_load),
      .thr_value      (thr_value)
   );

   assign slot_free  = !out_valid_ff || rsp_bus.ready;
   assign flush_mode = held_valid_ff && held_flush_ff;
   assign fire       = slot_free && (flush_mode || stg_valid_ff);
   assign stg_take   = fire && !flush_mode;
   assign emit       = fire && (flush_mode || held_valid_ff || stg_eos_ff);
   assign last       = flush_mode || !held_valid_ff || !stg_eos_ff;

   assign req_bus.ready = !stg_valid_ff || stg_take;

   // The held event is classified first; with nothing held, an end-of-stream
   // beat is classified straight from the input register.
   assign cls_ts  = held_valid_ff ? held_ts_ff : stg_ts_ff;
   assign cls_pay = held_valid_ff ? held_pay_ff : stg_pay_ff;
   assign cls_nxt = (held_valid_ff && !held_flush_ff) ? stg_ts_ff : cls_ts;

   ets_classify #(
      .TS_WIDTH (TS_WIDTH)
   ) u_classify (
      .cls_ts     (cls_ts),
      .cls_nxt    (cls_nxt),
      .offset     (offset_ff),
      .offset_thr (offset_thr_ff),
      .prev_kept  (prev_kept_ff),
      .prev_thr   (prev_thr_ff),
      .ts_minimum (ts_minimum),
      .ts_maximum (ts_maximum),
      .split_mode (split_mode),
      .cur        (cls_cur),
      .cur_thr    (cls_cur_thr),
      .flags      (cls_flags)
   );

   assign held_valid_in = flush_mode ? 1'b0 : (held_valid_ff || !stg_eos_ff);
   assign held_flush_in = !flush_mode && held_valid_ff && stg_eos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         stg_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         stg_ts_ff  <= req_bus.raw_timestamp;
         stg_pay_ff <= req_bus.event_payload;
         stg_eos_ff <= req_bus.end_of_stream;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_flush_ff <= 1'b0;
      end else if (fire) begin
         held_valid_ff <= held_valid_in;
         held_flush_ff <= held_flush_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stg_take) begin
         held_ts_ff  <= stg_ts_ff;
         held_pay_ff <= stg_pay_ff;
      end
   end

   // prev_thr_ff tracks prev_kept_ff + threshold and offset_thr_ff tracks
   // offset_ff + threshold; each is refreshed whenever its own terms change.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         offset_thr_ff <= '0;
         prev_kept_ff  <= '0;
         prev_thr_ff   <= '0;
      end else if (thr_load) begin
         offset_thr_ff <= offset_ff + thr_value;
         prev_thr_ff   <= prev_kept_ff + thr_value;
      end else if (emit && cls_flags.kept) begin
         prev_kept_ff <= cls_cur;
         prev_thr_ff  <= cls_cur_thr;
         if (cls_flags.load_offset) begin
            offset_ff     <= prev_kept_ff;
            offset_thr_ff <= prev_thr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (slot_free) begin
         out_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ts_ff      <= cls_cur;
         out_pay_ff     <= cls_pay;
         out_verdict_ff <= cls_flags.verdict;
         out_seg_ff     <= cls_flags.new_segment;
         out_last_ff    <= last;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.out_timestamp = out_ts_ff;
   assign rsp_bus.out_payload   = out_pay_ff;
   assign rsp_bus.verdict       = out_verdict_ff;
   assign rsp_bus.new_segment   = out_seg_ff;
   assign rsp_bus.run_last      = out_last_ff;

   // A pending flush only exists for an event that is actually held.
   a_flush_needs_held: assert property (@(posedge clock) disable iff (reset)
      held_flush_ff |-> held_valid_ff)
      else $error("flush pending without a held event");

   // Classifying the flushed event empties the hold.
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      (fire && flush_mode) |=> !held_valid_ff)
      else $error("held event survived its flush");

   // A result that is not the last of its beat always has its partner queued.
   a_partner_queued: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> held_flush_ff)
      else $error("non-final result without a pending flush");

   // Only kept events may open a new segment.
   a_segment_kept: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_seg_ff) |-> (out_verdict_ff == VERDICT_KEPT))
      else $error("new segment flagged on a dropped event");

endmodule

`default_nettype wire

// ----- sim/event_timestamp_sanitizer_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Event timestamp sanitizer testbench
// Drives event records through the valid/ready input, programs the range,
// threshold and split registers over the APB port between streams, and
// checks every classified record against a behavioural predictor that
// keeps its own copy of the held event, last kept timestamp and offset.
// A short directed list covers the edge cases; randomised streams follow.
// ----------------------------------------------------------------------------
module event_timestamp_sanitizer_unit_tb;
   import ets_pkg::*;

   localparam int TS_W = TS_WIDTH_DEFAULT;
   localparam int PL_W = PAYLOAD_WIDTH_DEFAULT;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [63:0] timestamp;
      logic [63:0] payload;
      verdict_type verdict;
      logic        new_segment;
      logic        run_last;
   } graded_event_type;

   typedef enum logic { ROW_EVENT, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type  kind;
      csr_index_type reg_index;
      logic [63:0]   value;
      logic [63:0]   raw_ts;
      logic [63:0]   payload;
      logic          eos;
      logic          typed;
      verdict_type   want_verdict;
      logic [63:0]   want_ts;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   ets_req_if #(.TS_WIDTH(TS_W), .PAYLOAD_WIDTH(PL_W)) req_bus ();
   ets_rsp_if #(.TS_WIDTH(TS_W), .PAYLOAD_WIDTH(PL_W)) rsp_bus ();

   event_timestamp_sanitizer_unit #(
      .TS_WIDTH      (TS_W),
      .PAYLOAD_WIDTH (PL_W)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predictor state and configuration copy.
   logic [63:0] cfg_minimum   = '0;
   logic [63:0] cfg_maximum   = ALL_ONES;
   logic [63:0] cfg_threshold = '0;
   logic        cfg_split     = 1'b0;
   logic [63:0] hold_ts       = '0;
   logic [63:0] hold_payload  = '0;
   logic        hold_valid    = 1'b0;
   logic [63:0] last_kept     = '0;
   logic [63:0] ts_offset     = '0;

   graded_event_type graded_queue[$];
   stim_row_type     directed_rows[$];
   int unsigned      mismatches    = 0;
   int               send_gap_pct  = 24;
   int               stall_pct     = 47;
   bit               stall_request = 1'b0;

   // Classifies one event against the last kept timestamp and the corrected
   // lookahead, updating the kept timestamp and offset as the block does.
   function automatic graded_event_type grade_event(input logic [63:0] raw_ts,
                                                    input logic [63:0] payload,
                                                    input logic [63:0] lookahead);
      graded_event_type g;
      logic [63:0]      corrected;
      logic [63:0]      prev_reach;
      logic [63:0]      cur_reach;
      logic [63:0]      next_reach;
      corrected     = raw_ts + ts_offset;
      prev_reach    = last_kept + cfg_threshold;
      cur_reach     = corrected + cfg_threshold;
      next_reach    = lookahead + cfg_threshold;
      g.timestamp   = corrected;
      g.payload     = payload;
      g.new_segment = 1'b0;
      g.run_last    = 1'b0;
      if (raw_ts < cfg_minimum || raw_ts > cfg_maximum) begin
         g.verdict = VERDICT_OUT_OF_RANGE;
      end else if (prev_reach < corrected && lookahead < prev_reach) begin
         g.verdict = VERDICT_FORWARD;
      end else if (cur_reach < last_kept && last_kept < next_reach) begin
         g.verdict = VERDICT_BACKWARD;
      end else begin
         g.verdict = VERDICT_KEPT;
         // Both this event and the next lie well below: a genuine step back.
         if (cur_reach < last_kept && next_reach < last_kept) begin
            if (cfg_split) begin
               g.new_segment = 1'b1;
            end else begin
               ts_offset = last_kept;
            end
         end
         last_kept = corrected;
      end
      return g;
   endfunction

   function automatic void predict_beat(input logic [63:0] raw_ts,
                                        input logic [63:0] payload,
                                        input logic eos);
      int n;
      n = 0;
      if (hold_valid) begin
         graded_queue.push_back(grade_event(hold_ts, hold_payload, raw_ts + ts_offset));
         n++;
      end
      if (eos) begin
         // The flushed event is its own lookahead, under the offset now in force.
         graded_queue.push_back(grade_event(raw_ts, payload, raw_ts + ts_offset));
         n++;
         hold_valid   = 1'b0;
         hold_ts      = '0;
         hold_payload = '0;
      end else begin
         hold_valid   = 1'b1;
         hold_ts      = raw_ts;
         hold_payload = payload;
      end
      if (n > 0) begin
         graded_queue[graded_queue.size() - 1].run_last = 1'b1;
      end
   endfunction

   function automatic stim_row_type beat_row(input logic [63:0] raw_ts,
                                             input logic [63:0] payload,
                                             input logic eos);
      stim_row_type r;
      r.kind         = ROW_EVENT;
      r.reg_index    = REG_TS_MINIMUM;
      r.value        = '0;
      r.raw_ts       = raw_ts;
      r.payload      = payload;
      r.eos          = eos;
      r.typed        = 1'b0;
      r.want_verdict = VERDICT_KEPT;
      r.want_ts      = '0;
      return r;
   endfunction

   function automatic stim_row_type checked_row(input logic [63:0] raw_ts,
                                                input logic [63:0] payload,
                                                input logic eos,
                                                input verdict_type want_verdict,
                                                input logic [63:0] want_ts);
      stim_row_type r;
      r              = beat_row(raw_ts, payload, eos);
      r.typed        = 1'b1;
      r.want_verdict = want_verdict;
      r.want_ts      = want_ts;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input csr_index_type idx,
                                            input logic [63:0] value);
      stim_row_type r;
      r           = beat_row('0, '0, 1'b0);
      r.kind      = ROW_CSR;
      r.reg_index = idx;
      r.value     = value;
      return r;
   endfunction

   task automatic wait_drained();
      req_bus.valid = 1'b0;
      while (graded_queue.size() != 0) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      wait_drained();
      // Let the pipeline settle after the last result before touching a register.
      repeat (6) @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = CSR_ADDR_WIDTH'(idx) << CSR_INDEX_LSB;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_TS_MINIMUM:     cfg_minimum   = value;
         REG_TS_MAXIMUM:     cfg_maximum   = value;
         REG_JUMP_THRESHOLD: cfg_threshold = value;
         REG_SPLIT_MODE:     cfg_split     = value[0];
         default: ;
      endcase
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic send_beat(input logic [63:0] raw_ts,
                            input logic [63:0] payload,
                            input logic eos);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid         = 1'b1;
      req_bus.raw_timestamp = raw_ts;
      req_bus.event_payload = payload;
      req_bus.end_of_stream = eos;
      do @(posedge clock); while (!req_bus.ready);
      predict_beat(raw_ts, payload, eos);
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin
      int unsigned hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            hold_left     = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      graded_event_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (graded_queue.size() == 0) begin
            mismatches++;
            $display("%t: unexpected result ts=%h payload=%h verdict=%0d seg=%b last=%b",
                     $time, rsp_bus.out_timestamp, rsp_bus.out_payload,
                     rsp_bus.verdict, rsp_bus.new_segment, rsp_bus.run_last);
         end else begin
            want = graded_queue.pop_front();
            if (rsp_bus.out_timestamp !== want.timestamp ||
                rsp_bus.out_payload !== want.payload ||
                rsp_bus.verdict !== want.verdict ||
                rsp_bus.new_segment !== want.new_segment ||
                rsp_bus.run_last !== want.run_last) begin
               mismatches++;
               $display("%t: expected ts=%h payload=%h verdict=%0d seg=%b last=%b",
                        $time, want.timestamp, want.payload, want.verdict,
                        want.new_segment, want.run_last);
               $display("%t:   actual ts=%h payload=%h verdict=%0d seg=%b last=%b",
                        $time, rsp_bus.out_timestamp, rsp_bus.out_payload,
                        rsp_bus.verdict, rsp_bus.new_segment, rsp_bus.run_last);
            end
         end
      end
   end

   initial begin
      logic [63:0] walk_ts;
      logic [63:0] raw_ts;
      logic [63:0] jump;
      logic [63:0] step_cap;
      logic [63:0] range_lo;
      logic [63:0] range_hi;
      logic [63:0] thr;
      logic        eos;
      int          pick;

      reset                 = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_bus.valid         = 1'b0;
      req_bus.raw_timestamp = '0;
      req_bus.event_payload = '0;
      req_bus.end_of_stream = 1'b0;

      // Reset values first: the opening event is only held, then an end of
      // stream flushes it with the new event as lookahead, then itself.
      directed_rows.push_back(beat_row(64'd0, 64'd0, 1'b0));
      directed_rows.push_back(checked_row(ALL_ONES, ALL_ONES, 1'b1, VERDICT_KEPT, ALL_ONES));
      // End of stream with nothing held; a genuine step back sets the offset.
      directed_rows.push_back(beat_row(64'd5, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
      directed_rows.push_back(csr_row(REG_TS_MINIMUM, 64'd8));
      directed_rows.push_back(csr_row(REG_TS_MAXIMUM, 64'h0000_0100_0000_0000));
      directed_rows.push_back(csr_row(REG_JUMP_THRESHOLD, 64'd100));
      directed_rows.push_back(beat_row(64'd1001, 64'h5555_5555_5555_5555, 1'b0));
      directed_rows.push_back(beat_row(64'd1011, 64'd1, 1'b0));
      directed_rows.push_back(beat_row(64'd100001, 64'd2, 1'b0));
      directed_rows.push_back(checked_row(64'd1021, 64'd3, 1'b0, VERDICT_FORWARD,
                                          64'd100000));
      directed_rows.push_back(beat_row(64'd11, 64'd4, 1'b0));
      directed_rows.push_back(checked_row(64'd1031, 64'd5, 1'b0, VERDICT_BACKWARD, 64'd10));
      directed_rows.push_back(beat_row(64'd1, 64'd6, 1'b0));
      directed_rows.push_back(checked_row(64'd21, 64'd7, 1'b0, VERDICT_OUT_OF_RANGE, 64'd0));
      directed_rows.push_back(beat_row(64'd31, 64'd8, 1'b0));
      directed_rows.push_back(beat_row(64'd41, 64'd9, 1'b1));
      // Split mode, with a record above the upper limit.
      directed_rows.push_back(csr_row(REG_SPLIT_MODE, 64'd1));
      directed_rows.push_back(beat_row(64'd2000, 64'd10, 1'b0));
      directed_rows.push_back(beat_row(64'd2010, 64'd11, 1'b0));
      directed_rows.push_back(beat_row(64'h0000_0100_0000_0001, 64'd12, 1'b0));
      directed_rows.push_back(checked_row(64'd100, 64'd13, 1'b0, VERDICT_OUT_OF_RANGE,
                                          64'h0000_0100_0000_0407));
      directed_rows.push_back(beat_row(64'd110, 64'd14, 1'b0));
      directed_rows.push_back(beat_row(64'd120, 64'd15, 1'b1));
      // Widest settings, where every threshold sum wraps.
      directed_rows.push_back(csr_row(REG_JUMP_THRESHOLD, ALL_ONES));
      directed_rows.push_back(csr_row(REG_TS_MINIMUM, 64'd0));
      directed_rows.push_back(csr_row(REG_TS_MAXIMUM, ALL_ONES));
      directed_rows.push_back(csr_row(REG_SPLIT_MODE, 64'hFFFF_FFFF_FFFF_FFFE));
      directed_rows.push_back(beat_row(ALL_ONES, ALL_ONES, 1'b0));
      directed_rows.push_back(beat_row(64'd0, 64'd0, 1'b0));
      directed_rows.push_back(beat_row(ALL_ONES, 64'd0, 1'b1));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            csr_write(directed_rows[i].reg_index, directed_rows[i].value);
         end else begin
            send_beat(directed_rows[i].raw_ts, directed_rows[i].payload,
                      directed_rows[i].eos);
            if (directed_rows[i].typed) begin
               graded_queue[graded_queue.size() - 1].verdict = directed_rows[i].want_verdict;
               graded_queue[graded_queue.size() - 1].timestamp = directed_rows[i].want_ts;
            end
         end
      end

      for (int ph = 0; ph < 12; ph++) begin
         send_gap_pct = (ph < 4) ? 24 : (ph < 8) ? 47 : 0;
         stall_pct    = (ph < 4) ? 47 : (ph < 8) ? 24 : 0;

         case ($urandom_range(0, 3))
            0: walk_ts = {32'd0, $urandom};
            1: walk_ts = {$urandom, $urandom};
            2: walk_ts = 64'hFFFF_FFFF_FFFF_0000 + 64'($urandom_range(0, 60000));
            default: walk_ts = 64'($urandom_range(0, 1000));
         endcase
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            range_lo = '0;
            range_hi = ALL_ONES;
            thr      = '0;
         end else if (pick == 1) begin
            range_lo = '0;
            range_hi = ALL_ONES;
            thr      = ALL_ONES;
         end else if (pick == 2) begin
            range_lo = {$urandom, $urandom};
            range_hi = {$urandom, $urandom};
            thr      = {$urandom, $urandom};
         end else begin
            range_lo = walk_ts - 64'($urandom_range(0, 20000));
            range_hi = walk_ts + {24'd0, 8'($urandom_range(1, 255)), $urandom};
            thr      = 64'($urandom_range(0, 2000));
         end
         csr_write(REG_TS_MINIMUM, range_lo);
         csr_write(REG_TS_MAXIMUM, range_hi);
         csr_write(REG_JUMP_THRESHOLD, thr);
         csr_write(REG_SPLIT_MODE, {$urandom, $urandom});
         step_cap = (cfg_threshold > 64'd4000) ? 64'd4000 : cfg_threshold + 64'd1;

         for (int k = 0; k < 90; k++) begin
            if (ph == 1 && k == 20) begin
               stall_request = 1'b1;
            end
            if (ph == 5 && k == 40) begin
               wait_drained();
            end
            jump = cfg_threshold + 64'($urandom_range(1, 100000));
            pick = $urandom_range(0, 99);
            // Mostly a steady walk, with isolated spikes either way, genuine
            // steps back and forward, and the odd record anywhere at all.
            if (pick < 62) begin
               walk_ts = walk_ts + 64'($urandom_range(0, 32'(step_cap)));
               raw_ts  = walk_ts;
            end else if (pick < 72) begin
               raw_ts = walk_ts + jump;
            end else if (pick < 80) begin
               raw_ts = walk_ts - jump;
            end else if (pick < 88) begin
               walk_ts = walk_ts - jump;
               raw_ts  = walk_ts;
            end else if (pick < 94) begin
               raw_ts = {$urandom, $urandom};
            end else begin
               walk_ts = walk_ts + jump;
               raw_ts  = walk_ts;
            end
            eos = (k == 89) || ($urandom_range(0, 29) == 0);
            send_beat(raw_ts, {$urandom, $urandom}, eos);
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
